// File: hw/rtl/lrs_pkg.sv
`default_nettype none

package lrs_pkg;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 64;
    localparam int KEY_W   = 32;
    localparam int RANK_W  = 7;
    localparam int TOP_W   = 6;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_LEAD     = 32;
    localparam logic [TOP_W-1:0] TOP_COUNT_RST = TOP_W'(10);

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Register select is bit 2 of the byte address.
    localparam logic REG_ORDER_MODE = 1'b0;
    localparam logic REG_TOP_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     order_mode;
    } t_cell_ctl;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

    function automatic logic ranks_before(
        input logic [KEY_W-1:0] a,
        input logic [KEY_W-1:0] b,
        input logic             mode
    );
        logic res;
        if (mode == 1'b0) begin
            res = (a > b);
        end else begin
            res = (a != '0) && ((b == '0) || (a < b));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lrs_if.sv
`default_nettype none

interface lrs_in_if;
    logic                            valid;
    logic                            ready;
    logic [lrs_pkg::CMD_W-1:0]       cmd;
    logic [lrs_pkg::ID_W-1:0]        user_id;
    logic [lrs_pkg::KEY_W-1:0]       key_value;

    modport source (output valid, cmd, user_id, key_value, input ready);
    modport sink   (input valid, cmd, user_id, key_value, output ready);
endinterface

interface lrs_out_if;
    logic                            valid;
    logic                            ready;
    logic [lrs_pkg::RANK_W-1:0]      rank;
    logic [lrs_pkg::ID_W-1:0]        entry_id;
    logic [lrs_pkg::KEY_W-1:0]       entry_key;
    logic                            is_requester;
    logic                            last;

    modport source (output valid, rank, entry_id, entry_key, is_requester, last,
                    input ready);
    modport sink   (input valid, rank, entry_id, entry_key, is_requester, last,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lrs_ram.sv
`default_nettype none

module lrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lrs_cell.sv
`default_nettype none

module lrs_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lrs_pkg::t_cell_ctl i_ctl,
    input  wire lrs_pkg::t_entry   i_new,
    input  wire lrs_pkg::t_entry   i_prev,
    input  wire logic              i_prev_before,
    input  wire lrs_pkg::t_entry   i_next,
    output lrs_pkg::t_entry        o_entry,
    output logic                   o_new_before
);

    logic                      r_valid;
    logic [lrs_pkg::KEY_W-1:0] r_key;
    logic [lrs_pkg::ID_W-1:0]  r_id;

    // Equal keys do not displace: a later word lands behind them.
    assign o_new_before = !r_valid ||
                          lrs_pkg::ranks_before(i_new.key, r_key, i_ctl.order_mode);
    assign o_entry      = '{valid: r_valid, key: r_key, id: r_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_ctl.op)
                lrs_pkg::OP_CLEAR: begin
                    r_valid <= 1'b0;
                end
                lrs_pkg::OP_INSERT: begin
                    if (i_prev_before) begin
                        r_valid <= i_prev.valid;
                    end else if (o_new_before) begin
                        r_valid <= 1'b1;
                    end
                end
                lrs_pkg::OP_SHIFT: begin
                    r_valid <= i_next.valid;
                end
                default: begin
                    r_valid <= r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            lrs_pkg::OP_INSERT: begin
                if (i_prev_before) begin
                    r_key <= i_prev.key;
                    r_id  <= i_prev.id;
                end else if (o_new_before) begin
                    r_key <= i_new.key;
                    r_id  <= i_new.id;
                end
            end
            lrs_pkg::OP_SHIFT: begin
                r_key <= i_next.key;
                r_id  <= i_next.id;
            end
            default: begin
                r_key <= r_key;
                r_id  <= r_id;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/leaderboard_rank_sorter.sv
`default_nettype none

// Leaderboard sorter. Loads and clears complete without leaving the idle
// state. Entries are kept in load order in a single-port-read RAM; a query
// replays them one per cycle into a row of insertion cells that keep them
// sorted under the current order mode, then walks the sorted row one
// position per cycle while the output side is not stalled, emitting up to
// top_count (capped at MAX_LEAD) leading words plus the requester's own word
// if it ranks further down. The RAM read port sets the build time. Ties keep
// load order. A query into an empty store produces nothing; a load into a
// full store is dropped. No input is taken while a query is in progress; the
// last result may still be waiting at the output.
module leaderboard_rank_sorter #(
    parameter int CAPACITY = lrs_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lrs_in_if.sink                           i_in,
    lrs_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lrs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lrs_pkg::DATA_W-1:0]  pwdata,
    output logic      [lrs_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int LW    = (CW > lrs_pkg::TOP_W) ? CW : lrs_pkg::TOP_W;
    localparam int MEM_W = lrs_pkg::KEY_W + lrs_pkg::ID_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_EMIT
    } t_state;

    t_state                         r_state;
    logic                           r_order_mode;
    logic [lrs_pkg::TOP_W-1:0]      r_top_count;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_rd_addr;
    logic                           r_rd_v;
    logic [lrs_pkg::ID_W-1:0]       r_req_id;
    logic                           r_present;
    logic                           r_seen;
    logic [CW-1:0]                  r_pos;
    logic [LW-1:0]                  r_lead;
    logic                           r_out_valid;
    logic [lrs_pkg::RANK_W-1:0]     r_out_rank;
    logic [lrs_pkg::ID_W-1:0]       r_out_id;
    logic [lrs_pkg::KEY_W-1:0]      r_out_key;
    logic                           r_out_req;
    logic                           r_out_last;

    logic                           w_in_acc;
    logic                           w_cfg_wr;
    logic [lrs_pkg::TOP_W-1:0]      w_capped;
    logic [LW-1:0]                  w_lead;
    logic                           w_full;
    logic                           w_ram_we;
    logic                           w_ram_re;
    logic [MEM_W-1:0]               w_ram_rdata;
    lrs_pkg::t_entry                w_new;
    lrs_pkg::t_cell_ctl             w_ctl;
    lrs_pkg::t_entry                w_ent      [CAPACITY];
    logic                           w_before   [CAPACITY];
    lrs_pkg::t_entry                w_prev_ent [CAPACITY];
    logic                           w_prev_bef [CAPACITY];
    lrs_pkg::t_entry                w_next_ent [CAPACITY];
    lrs_pkg::t_entry                w_head;
    logic                           w_can_push;
    logic                           w_match;
    logic                           w_in_lead;
    logic                           w_lead_end;
    logic                           w_shift;
    logic                           w_push;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            lrs_pkg::REG_ORDER_MODE: prdata = lrs_pkg::DATA_W'(r_order_mode);
            lrs_pkg::REG_TOP_COUNT:  prdata = lrs_pkg::DATA_W'(r_top_count);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= 1'b0;
            r_top_count  <= lrs_pkg::TOP_COUNT_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == lrs_pkg::REG_ORDER_MODE) begin
                r_order_mode <= pwdata[0];
            end else begin
                r_top_count <= pwdata[lrs_pkg::TOP_W-1:0];
            end
        end
    end

    // ---------------- load-order store ----------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_ram_we   = w_in_acc && (i_in.cmd == lrs_pkg::CMD_LOAD) && !w_full;
    assign w_ram_re   = (r_state == ST_FEED) && (r_rd_addr != r_count);

    lrs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in.key_value, i_in.user_id}),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_new = '{valid: 1'b1,
                     key:   w_ram_rdata[MEM_W-1 -: lrs_pkg::KEY_W],
                     id:    w_ram_rdata[lrs_pkg::ID_W-1:0]};

    // ---------------- sorting row ----------------
    assign w_capped = (r_top_count > lrs_pkg::TOP_W'(lrs_pkg::MAX_LEAD)) ?
                      lrs_pkg::TOP_W'(lrs_pkg::MAX_LEAD) : r_top_count;
    assign w_lead   = (LW'(w_capped) < LW'(r_count)) ? LW'(w_capped) : LW'(r_count);

    always_comb begin
        w_ctl.order_mode = r_order_mode;
        if (w_in_acc && (i_in.cmd == lrs_pkg::CMD_QUERY)) begin
            w_ctl.op = lrs_pkg::OP_CLEAR;
        end else if ((r_state == ST_FEED) && r_rd_v) begin
            w_ctl.op = lrs_pkg::OP_INSERT;
        end else if (w_shift) begin
            w_ctl.op = lrs_pkg::OP_SHIFT;
        end else begin
            w_ctl.op = lrs_pkg::OP_HOLD;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev_ent[g] = '0;
            assign w_prev_bef[g] = 1'b0;
        end else begin : g_mid
            assign w_prev_ent[g] = w_ent[g-1];
            assign w_prev_bef[g] = w_before[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_ent[g] = '0;
        end else begin : g_body
            assign w_next_ent[g] = w_ent[g+1];
        end

        lrs_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new         (w_new),
            .i_prev        (w_prev_ent[g]),
            .i_prev_before (w_prev_bef[g]),
            .i_next        (w_next_ent[g]),
            .o_entry       (w_ent[g]),
            .o_new_before  (w_before[g])
        );
    end

    // ---------------- result walk ----------------
    assign w_head     = w_ent[0];
    assign w_can_push = !r_out_valid || o_out.ready;
    assign w_match    = (w_head.id == r_req_id);
    assign w_in_lead  = (LW'(r_pos) < r_lead);
    assign w_lead_end = ((LW'(r_pos) + LW'(1)) == r_lead);

    always_comb begin
        w_shift = 1'b0;
        w_push  = 1'b0;
        if (r_state == ST_EMIT) begin
            if (w_in_lead) begin
                w_shift = w_can_push;
                w_push  = w_can_push;
            end else if (!r_seen && r_present && !w_match) begin
                w_shift = 1'b1;
            end else if (!r_seen && r_present) begin
                w_push  = w_can_push;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rank         = r_out_rank;
    assign o_out.entry_id     = r_out_id;
    assign o_out.entry_key    = r_out_key;
    assign o_out.is_requester = r_out_req;
    assign o_out.last         = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_addr   <= '0;
            r_rd_v      <= 1'b0;
            r_present   <= 1'b0;
            r_seen      <= 1'b0;
            r_pos       <= '0;
            r_lead      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.cmd)
                            lrs_pkg::CMD_LOAD: begin
                                if (!w_full) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            lrs_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                            end
                            lrs_pkg::CMD_QUERY: begin
                                if (r_count != '0) begin
                                    r_state   <= ST_FEED;
                                    r_rd_addr <= '0;
                                    r_rd_v    <= 1'b0;
                                    r_req_id  <= i_in.user_id;
                                    r_present <= 1'b0;
                                    r_seen    <= 1'b0;
                                    r_pos     <= '0;
                                    r_lead    <= w_lead;
                                end
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                ST_FEED: begin
                    r_rd_v <= w_ram_re;
                    if (w_ram_re) begin
                        r_rd_addr <= r_rd_addr + CW'(1);
                    end
                    if (r_rd_v && (w_new.id == r_req_id)) begin
                        r_present <= 1'b1;
                    end
                    if (!w_ram_re && !r_rd_v) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_in_lead) begin
                        if (w_can_push) begin
                            r_out_rank  <= lrs_pkg::RANK_W'(r_pos + CW'(1));
                            r_out_id    <= w_head.id;
                            r_out_key   <= w_head.key;
                            r_out_req   <= w_match;
                            r_out_last  <= w_lead_end && (r_seen || w_match || !r_present);
                            r_pos       <= r_pos + CW'(1);
                            if (w_match) begin
                                r_seen <= 1'b1;
                            end
                            if (w_lead_end && (r_seen || w_match || !r_present)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end else if (r_seen || !r_present) begin
                        r_state <= ST_IDLE;
                    end else if (w_match) begin
                        if (w_can_push) begin
                            r_out_rank  <= lrs_pkg::RANK_W'(r_pos + CW'(1));
                            r_out_id    <= w_head.id;
                            r_out_key   <= w_head.key;
                            r_out_req   <= 1'b1;
                            r_out_last  <= 1'b1;
                            r_state     <= ST_IDLE;
                        end
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lrs_checker.sv
`default_nettype none

module lrs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic [lrs_pkg::CMD_W-1:0]     i_in_cmd,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [lrs_pkg::RANK_W-1:0]    i_out_rank,
    input wire logic [lrs_pkg::ID_W-1:0]      i_out_id,
    input wire logic                          i_out_last
);

    // A stalled word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_rank) && $stable(i_out_id) && $stable(i_out_last))
        else $error("output word changed while stalled");

    // Loads and clears leave the input ready again in the cycle after they are taken.
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd != lrs_pkg::CMD_QUERY) |=> i_in_ready)
        else $error("input not ready after load or clear");

    // A query keeps the input closed until its final word is produced.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |-> !i_in_ready)
        else $error("input opened before query finished");

    // Ranks are one-based.
    a_rank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_rank != '0))
        else $error("zero rank emitted");

endmodule

bind leaderboard_rank_sorter lrs_checker u_lrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rank  (o_out.rank),
    .i_out_id    (o_out.entry_id),
    .i_out_last  (o_out.last)
);

`default_nettype wire
